>>> hw/rtl/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

   // cache geometry and field widths
   localparam int ENTRIES    = 128;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 32;

   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int RANK_BITS = IDX_BITS;

   typedef logic [KEY_BITS-1:0]          key_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic [CNT_BITS-1:0]          cnt_type;
   typedef logic [RANK_BITS-1:0]         rank_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic    start;
      logic    scan;
      logic    decide;
      logic    update;
      logic    load_rsp;
      idx_type addr;
   } cmd_type;

endpackage

>>> hw/rtl/lru_req_if.sv
`timescale 1ns / 1ps

interface lru_req_if import lru_pkg::*; ();
   logic      valid;
   logic      ready;
   key_type   key;
   value_type fill_value;

   modport source (output valid, output key, output fill_value, input ready);
   modport sink (input valid, input key, input fill_value, output ready);
endinterface

>>> hw/rtl/lru_rsp_if.sv
`timescale 1ns / 1ps

interface lru_rsp_if import lru_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      hit;
   value_type value;
   logic      evicted;
   key_type   evicted_key;

   modport source (output valid, output hit, output value, output evicted,
                   output evicted_key, input ready);
   modport sink (input valid, input hit, input value, input evicted,
                 input evicted_key, output ready);
endinterface

>>> hw/rtl/lru_ram.sv
`timescale 1ns / 1ps

module lru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/lru_ctrl.sv
`timescale 1ns / 1ps

module lru_ctrl import lru_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_UPDATE,
      S_DONE
   } state_type;

   state_type state_ff;
   cnt_type   cnt_ff;
   logic      rsp_valid_ff;
   logic      cnt_end;

   assign cnt_end   = (cnt_ff == CNT_BITS'(ENTRIES));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.addr     = cnt_ff[IDX_BITS-1:0];
      cmd.start    = (state_ff == S_IDLE) && req_valid;
      cmd.scan     = (state_ff == S_SCAN) && !cnt_end;
      cmd.decide   = (state_ff == S_DECIDE);
      cmd.update   = (state_ff == S_UPDATE) && !cnt_end;
      cmd.load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // sequencer: scan pass, decision, rank update pass, result hand-off
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_SCAN;
                  cnt_ff   <= '0;
               end
            end
            S_SCAN: begin
               if (cnt_end) begin
                  state_ff <= S_DECIDE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_BITS'(1);
               end
            end
            S_DECIDE: begin
               state_ff <= S_UPDATE;
               cnt_ff   <= '0;
            end
            S_UPDATE: begin
               if (cnt_end) begin
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_BITS'(1);
               end
            end
            S_DONE: begin
               if (cmd.load_rsp) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> hw/rtl/lru_dpath.sv
`timescale 1ns / 1ps

module lru_dpath import lru_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  key_type   req_key,
   input  value_type req_fill_value,
   output logic      rsp_hit,
   output value_type rsp_value,
   output logic      rsp_evicted,
   output key_type   rsp_evicted_key
);

   // captured item
   key_type   key_ff;
   value_type fill_ff;

   // entry state held in flops
   logic [ENTRIES-1:0] valid_ff;
   cnt_type            used_ff;

   // read pipeline tracking
   logic    scan_live_ff;
   logic    upd_live_ff;
   idx_type rd_idx_ff;

   // scan trackers
   logic      match_ff;
   idx_type   match_idx_ff;
   rank_type  match_rank_ff;
   value_type match_value_ff;
   logic      free_ff;
   idx_type   free_idx_ff;
   logic      max_ff;
   idx_type   max_idx_ff;
   rank_type  max_rank_ff;
   key_type   max_key_ff;

   // decision results
   idx_type   slot_ff;
   rank_type  old_rank_ff;
   logic      res_hit_ff;
   value_type res_value_ff;
   logic      res_ev_ff;
   key_type   res_ev_key_ff;

   // output register
   logic      rsp_hit_ff;
   value_type rsp_value_ff;
   logic      rsp_ev_ff;
   key_type   rsp_ev_key_ff;

   // memory ports
   key_type                key_rdata;
   logic [VALUE_BITS-1:0]  value_rdata;
   rank_type               rank_raw;
   rank_type               rank_rd;
   logic                   entry_valid;
   logic                   kv_wr_en;
   logic                   rank_wr_en;
   rank_type               rank_wr_data;

   // decision logic
   idx_type  slot_in;
   rank_type old_rank_in;
   logic     ev_in;
   logic     fix_in;
   logic     full;

   assign entry_valid = valid_ff[rd_idx_ff];
   // an entry never made valid reads as rank zero
   assign rank_rd     = entry_valid ? rank_raw : '0;
   assign full        = (used_ff == CNT_BITS'(ENTRIES));
   assign kv_wr_en    = cmd.decide && !match_ff;

   // aging of newer entries and zero rank for the promoted slot
   always_comb begin
      rank_wr_en   = 1'b0;
      rank_wr_data = rank_rd + RANK_BITS'(1);
      if (upd_live_ff && entry_valid) begin
         if (rd_idx_ff == slot_ff) begin
            rank_wr_en   = 1'b1;
            rank_wr_data = '0;
         end else if (rank_rd < old_rank_ff) begin
            rank_wr_en = 1'b1;
         end
      end
   end

   // slot and old rank after the scan
   always_comb begin
      slot_in     = match_idx_ff;
      old_rank_in = match_rank_ff;
      ev_in       = 1'b0;
      fix_in      = 1'b0;
      priority if (match_ff) begin
         slot_in     = match_idx_ff;
         old_rank_in = match_rank_ff;
      end else if (!full && free_ff) begin
         slot_in     = free_idx_ff;
         old_rank_in = used_ff[RANK_BITS-1:0];
      end else if (max_ff) begin
         slot_in     = max_idx_ff;
         old_rank_in = max_rank_ff;
         ev_in       = 1'b1;
      end else begin
         // full count with no valid entry: take entry zero
         slot_in     = '0;
         old_rank_in = '0;
         fix_in      = 1'b1;
      end
   end

   lru_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (kv_wr_en),
      .wr_addr (slot_in),
      .wr_data (key_ff),
      .rd_addr (cmd.addr),
      .rd_data (key_rdata)
   );

   lru_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (kv_wr_en),
      .wr_addr (slot_in),
      .wr_data (fill_ff),
      .rd_addr (cmd.addr),
      .rd_data (value_rdata)
   );

   lru_ram #(.WIDTH(RANK_BITS), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rd_idx_ff),
      .wr_data (rank_wr_data),
      .rd_addr (cmd.addr),
      .rd_data (rank_raw)
   );

   // item capture, scan, decision and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         scan_live_ff <= 1'b0;
         upd_live_ff  <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         max_ff       <= 1'b0;
      end else begin
         scan_live_ff <= cmd.scan;
         upd_live_ff  <= cmd.update;
         rd_idx_ff    <= cmd.addr;

         if (cmd.start) begin
            key_ff   <= req_key;
            fill_ff  <= req_fill_value;
            match_ff <= 1'b0;
            free_ff  <= 1'b0;
            max_ff   <= 1'b0;
         end

         // one entry per cycle from the registered reads
         if (scan_live_ff) begin
            if (entry_valid && key_rdata == key_ff && !match_ff) begin
               match_ff       <= 1'b1;
               match_idx_ff   <= rd_idx_ff;
               match_rank_ff  <= rank_rd;
               match_value_ff <= value_type'(value_rdata);
            end
            if (!entry_valid && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= rd_idx_ff;
            end
            if (entry_valid && (!max_ff || rank_rd > max_rank_ff)) begin
               max_ff      <= 1'b1;
               max_idx_ff  <= rd_idx_ff;
               max_rank_ff <= rank_rd;
               max_key_ff  <= key_rdata;
            end
         end

         if (cmd.decide) begin
            slot_ff       <= slot_in;
            old_rank_ff   <= old_rank_in;
            res_hit_ff    <= match_ff;
            res_value_ff  <= match_ff ? match_value_ff : fill_ff;
            res_ev_ff     <= ev_in;
            res_ev_key_ff <= ev_in ? max_key_ff : '0;
            if (!match_ff) begin
               valid_ff[slot_in] <= 1'b1;
            end
            if (fix_in) begin
               used_ff <= CNT_BITS'(1);
            end else if (!match_ff && !ev_in) begin
               used_ff <= used_ff + CNT_BITS'(1);
            end
         end

         if (cmd.load_rsp) begin
            rsp_hit_ff    <= res_hit_ff;
            rsp_value_ff  <= res_value_ff;
            rsp_ev_ff     <= res_ev_ff;
            rsp_ev_key_ff <= res_ev_key_ff;
         end
      end
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_key = rsp_ev_key_ff;

   // fill count tracks the valid bits
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      used_ff == CNT_BITS'($countones(valid_ff)))
      else $error("fill count does not match valid entries");

   // the chosen slot is valid once the decision is taken
   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> valid_ff[slot_ff])
      else $error("chosen slot not valid after decision");

   // a miss with room left never evicts
   a_free_no_evict: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && !match_ff && !full) |=> !res_ev_ff)
      else $error("eviction while free entries remain");

endmodule

>>> hw/rtl/lru_cache_lookup_fill.sv
`timescale 1ns / 1ps

// Fully associative cache of ENTRIES key/value pairs with exact LRU replacement.
// Each request item carries a key and a fill value; one response item follows
// with hit, the value now held for the key, and on a miss into a full cache the
// evicted flag and the key of the least recently used entry. After an item is
// accepted, a scan pass reads the key, value and rank memories one entry a
// cycle through their single read port, a decision step picks the slot, and a
// second pass over the rank memory ages the newer entries before the response
// is loaded; no new item is accepted until then. Valid bits live in flops and
// clear at reset, so no clearing pass is needed. A new item is taken while the
// previous response still waits in its output register.

module lru_cache_lookup_fill import lru_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   lru_req_if.sink   req_ch,
   lru_rsp_if.source rsp_ch
);

   cmd_type cmd;

   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   lru_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_key         (req_ch.key),
      .req_fill_value  (req_ch.fill_value),
      .rsp_hit         (rsp_ch.hit),
      .rsp_value       (rsp_ch.value),
      .rsp_evicted     (rsp_ch.evicted),
      .rsp_evicted_key (rsp_ch.evicted_key)
   );

endmodule
